// ===== design/max_weight_bipartite_matching_top_defines.svh =====
// ---------------------------------------------------------------------------
// max_weight_bipartite_matching_top_defines
// assertion macros shared by the matching block
// ---------------------------------------------------------------------------
`ifndef MAX_WEIGHT_BIPARTITE_MATCHING_TOP_DEFINES_SVH
`define MAX_WEIGHT_BIPARTITE_MATCHING_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// property checked at the same edge
`define MWBM_ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent checked at the following edge
`define MWBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MWBM_ASSERT_NOW(lbl, clk, rst_n, prop, msg)
`define MWBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/mwbm_pkg.sv =====
// ---------------------------------------------------------------------------
// mwbm_pkg
// shared constants, codes and controller/datapath types
// ---------------------------------------------------------------------------
`default_nettype none
package mwbm_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = VIDX_W + 1;
  localparam int ADDR_W       = 2 * VIDX_W;
  localparam int LABEL_W      = 36;
  localparam int WEIGHT_W     = 21;
  localparam int TOTAL_W      = 33;
  localparam int SIZE_W       = 5;

  localparam logic signed [LABEL_W-1:0] ABSENT_LABEL = -36'sd268435456;

  // input item operation codes
  typedef enum logic [1:0] {
    OPC_CLEAR = 2'd0,
    OPC_WRITE = 2'd1,
    OPC_SOLVE = 2'd2,
    OPC_NONE  = 2'd3
  } in_op_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAX_RD,
    ST_MAX_CMP,
    ST_PSTART,
    ST_SCAN,
    ST_CHK,
    ST_POP,
    ST_AUG,
    ST_ADJ_RD,
    ST_ADJ_CMP,
    ST_APPLY,
    ST_TOT,
    ST_OUT
  } ctrl_state_t;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_WRITE,
    OP_INIT,
    OP_MAX_RD,
    OP_MAX_ACC,
    OP_PSTART,
    OP_SCAN_SKIP,
    OP_SCAN_RD,
    OP_HIT_FREE,
    OP_HIT_DESC,
    OP_HIT_STAY,
    OP_MISS,
    OP_POP,
    OP_AUG,
    OP_ADJ_INIT,
    OP_ADJ_SKIP_ROW,
    OP_ADJ_SKIP_COL,
    OP_ADJ_RD,
    OP_ADJ_ACC,
    OP_APPLY,
    OP_TOT,
    OP_EMIT
  } dp_op_t;

  // datapath status
  typedef struct packed {
    logic scan_end;
    logic col_vis;
    logic row_vis;
    logic eq_hit;
    logic partner_free;
    logic can_desc;
    logic depth_zero;
    logic ri_last;
    logic ci_last;
    logic start_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/mwbm_ctrl.sv =====
// ---------------------------------------------------------------------------
// mwbm_ctrl
// solve sequencer: steps the datapath through labelling, search and output
// ---------------------------------------------------------------------------
`default_nettype none
module mwbm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  mwbm_pkg::in_op_t     in_op,
  output logic                 in_stall,
  input  mwbm_pkg::dp_status_t st,
  output mwbm_pkg::dp_op_t     cmd
);
  import mwbm_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = OP_NONE;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OPC_CLEAR: cmd = OP_CLEAR;
            OPC_WRITE: cmd = OP_WRITE;
            OPC_SOLVE: begin
              cmd       = OP_INIT;
              state_nxt = ST_MAX_RD;
            end
            OPC_NONE:  cmd = OP_NONE;
            default:   cmd = OP_NONE;
          endcase
        end
      end
      ST_MAX_RD: begin
        cmd       = OP_MAX_RD;
        state_nxt = ST_MAX_CMP;
      end
      ST_MAX_CMP: begin
        cmd       = OP_MAX_ACC;
        state_nxt = (st.ci_last && st.ri_last) ? ST_PSTART : ST_MAX_RD;
      end
      ST_PSTART: begin
        cmd       = OP_PSTART;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (st.scan_end) begin
          state_nxt = ST_POP;
        end else if (st.col_vis) begin
          cmd = OP_SCAN_SKIP;
        end else begin
          cmd       = OP_SCAN_RD;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        priority if (!st.eq_hit) begin
          cmd       = OP_MISS;
          state_nxt = ST_SCAN;
        end else if (st.partner_free) begin
          cmd       = OP_HIT_FREE;
          state_nxt = ST_AUG;
        end else if (st.can_desc) begin
          cmd       = OP_HIT_DESC;
          state_nxt = ST_SCAN;
        end else begin
          cmd       = OP_HIT_STAY;
          state_nxt = ST_SCAN;
        end
      end
      ST_POP: begin
        if (st.depth_zero) begin
          cmd       = OP_ADJ_INIT;
          state_nxt = ST_ADJ_RD;
        end else begin
          cmd       = OP_POP;
          state_nxt = ST_SCAN;
        end
      end
      ST_AUG: begin
        cmd = OP_AUG;
        if (st.depth_zero) begin
          state_nxt = st.start_last ? ST_TOT : ST_PSTART;
        end
      end
      ST_ADJ_RD: begin
        priority if (!st.row_vis) begin
          cmd = OP_ADJ_SKIP_ROW;
          if (st.ri_last) begin
            state_nxt = ST_APPLY;
          end
        end else if (st.col_vis) begin
          cmd = OP_ADJ_SKIP_COL;
          if (st.ci_last && st.ri_last) begin
            state_nxt = ST_APPLY;
          end
        end else begin
          cmd       = OP_ADJ_RD;
          state_nxt = ST_ADJ_CMP;
        end
      end
      ST_ADJ_CMP: begin
        cmd       = OP_ADJ_ACC;
        state_nxt = (st.ci_last && st.ri_last) ? ST_APPLY : ST_ADJ_RD;
      end
      ST_APPLY: begin
        cmd       = OP_APPLY;
        state_nxt = ST_PSTART;
      end
      ST_TOT: begin
        cmd = OP_TOT;
        if (st.ri_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd = OP_EMIT;
          if (st.ci_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/mwbm_dp.sv =====
// ---------------------------------------------------------------------------
// mwbm_dp
// weight store, labels, search stack, matching and result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "max_weight_bipartite_matching_top_defines.svh"
module mwbm_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mwbm_pkg::dp_op_t                      cmd,
  output mwbm_pkg::dp_status_t                  st,
  input  logic                                  cfg_we,
  input  logic [mwbm_pkg::SIZE_W-1:0]           cfg_wdata,
  input  logic [mwbm_pkg::VIDX_W-1:0]           in_row_index,
  input  logic [mwbm_pkg::VIDX_W-1:0]           in_col_index,
  input  logic signed [mwbm_pkg::WEIGHT_W-1:0]  in_edge_weight,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [mwbm_pkg::VIDX_W-1:0]           out_column,
  output logic [mwbm_pkg::VIDX_W-1:0]           out_matched_row,
  output logic signed [mwbm_pkg::TOTAL_W-1:0]   out_total_weight,
  output logic                                  out_last
);
  import mwbm_pkg::*;

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;

  logic [SIZE_W-1:0]          size_r;
  logic [SIZE_W-1:0]          n_size;
  logic [SIZE_W-1:0]          n_m1;

  logic signed [WEIGHT_W-1:0] weight_mem [DEPTH];
  logic [DEPTH-1:0]           wvld_r;
  logic signed [WEIGHT_W-1:0] rd_data_r;
  logic                       rd_vld_r;

  logic signed [LABEL_W-1:0]  rl_r [MAX_VERTICES];
  logic signed [LABEL_W-1:0]  cl_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]    rv_r;
  logic [MAX_VERTICES-1:0]    cv_r;
  logic [VCNT_W-1:0]          partner_r [MAX_VERTICES];

  logic [VIDX_W-1:0]          stk_row_r  [MAX_VERTICES];
  logic [VCNT_W-1:0]          stk_next_r [MAX_VERTICES];
  logic [VIDX_W-1:0]          stk_via_r  [MAX_VERTICES];

  logic [VIDX_W-1:0]          depth_r;
  logic [VIDX_W-1:0]          ri_r;
  logic [VCNT_W-1:0]          ci_r;
  logic [VIDX_W-1:0]          start_r;
  logic signed [LABEL_W-1:0]  max_r;
  logic signed [LABEL_W-1:0]  delta_r;
  logic                       found_r;
  logic signed [LABEL_W-1:0]  total_r;

  logic                       out_valid_r;
  logic [VIDX_W-1:0]          out_column_r;
  logic [VIDX_W-1:0]          out_matched_row_r;
  logic signed [TOTAL_W-1:0]  out_total_weight_r;
  logic                       out_last_r;

  logic [VIDX_W-1:0]          ci_idx;
  logic [VIDX_W-1:0]          u_row;
  logic [VIDX_W-1:0]          rd_row;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          wr_addr;
  logic signed [LABEL_W-1:0]  w_eff;
  logic signed [LABEL_W-1:0]  rl_sel;
  logic signed [LABEL_W-1:0]  cl_sel;
  logic signed [LABEL_W-1:0]  pair_sum;
  logic signed [LABEL_W-1:0]  slack;
  logic signed [LABEL_W-1:0]  max_new;
  logic [VCNT_W-1:0]          partner_v;
  logic [VIDX_W-1:0]          partner_row;
  logic [VIDX_W-1:0]          depth_m1;

  // effective size: zero acts as one, large values saturate
  always_comb begin
    priority if (size_r == '0) begin
      n_size = SIZE_W'(1);
    end else if (size_r > SIZE_W'(MAX_VERTICES)) begin
      n_size = SIZE_W'(MAX_VERTICES);
    end else begin
      n_size = size_r;
    end
  end
  assign n_m1 = n_size - SIZE_W'(1);

  // operand selection
  assign ci_idx      = ci_r[VIDX_W-1:0];
  assign u_row       = stk_row_r[depth_r];
  assign rd_row      = (cmd == OP_SCAN_RD) ? u_row : ri_r;
  assign rd_addr     = {rd_row, ci_idx};
  assign wr_addr     = {in_row_index, in_col_index};
  assign w_eff       = rd_vld_r ? {{(LABEL_W-WEIGHT_W){rd_data_r[WEIGHT_W-1]}}, rd_data_r}
                                : ABSENT_LABEL;
  assign rl_sel      = rl_r[ri_r];
  assign cl_sel      = cl_r[ci_idx];
  assign pair_sum    = rl_sel + cl_sel;
  assign slack       = pair_sum - w_eff;
  assign max_new     = ((ci_r == '0) || (w_eff > max_r)) ? w_eff : max_r;
  assign partner_v   = partner_r[ci_idx];
  assign partner_row = VIDX_W'(partner_v - VCNT_W'(1));
  assign depth_m1    = depth_r - VIDX_W'(1);

  // status to the sequencer
  always_comb begin
    st.scan_end     = (ci_r >= n_size);
    st.col_vis      = cv_r[ci_idx];
    st.row_vis      = rv_r[ri_r];
    st.eq_hit       = (pair_sum == w_eff);
    st.partner_free = (partner_v == '0);
    st.can_desc     = (depth_r != VIDX_W'(MAX_VERTICES - 1));
    st.depth_zero   = (depth_r == '0);
    st.ri_last      = ({1'b0, ri_r} == n_m1);
    st.ci_last      = (ci_r == n_m1);
    st.start_last   = ({1'b0, start_r} == n_m1);
    st.out_free     = !out_valid_r || !out_stall;
  end

  // control state: size register, weight valid bits, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_W'(MAX_VERTICES);
      wvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (cmd == OP_CLEAR) begin
        wvld_r <= '0;
      end else if (cmd == OP_WRITE) begin
        wvld_r[wr_addr] <= 1'b1;
      end
      if (cmd == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // weight memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd == OP_WRITE) begin
      weight_mem[wr_addr] <= in_edge_weight;
    end
    rd_data_r <= weight_mem[rd_addr];
    rd_vld_r  <= wvld_r[rd_addr];
  end

  // solve datapath
  always_ff @(posedge clk) begin
    unique case (cmd)
      OP_INIT: begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
          rl_r[k]      <= '0;
          cl_r[k]      <= '0;
          partner_r[k] <= '0;
        end
        ri_r    <= '0;
        ci_r    <= '0;
        start_r <= '0;
      end
      OP_MAX_ACC: begin
        max_r <= max_new;
        if (st.ci_last) begin
          rl_r[ri_r] <= max_new;
          ri_r       <= ri_r + VIDX_W'(1);
          ci_r       <= '0;
        end else begin
          ci_r <= ci_r + VCNT_W'(1);
        end
      end
      OP_PSTART: begin
        // only the start row is marked visited
        rv_r          <= MAX_VERTICES'(1) << start_r;
        cv_r          <= '0;
        depth_r       <= '0;
        stk_row_r[0]  <= start_r;
        stk_next_r[0] <= '0;
        stk_via_r[0]  <= '0;
        ci_r          <= '0;
      end
      OP_SCAN_SKIP, OP_MISS: begin
        ci_r <= ci_r + VCNT_W'(1);
      end
      OP_SCAN_RD: begin
        ri_r <= u_row;
      end
      OP_HIT_FREE: begin
        cv_r[ci_idx]        <= 1'b1;
        stk_next_r[depth_r] <= ci_r + VCNT_W'(1);
        stk_via_r[depth_r]  <= ci_idx;
      end
      OP_HIT_STAY: begin
        cv_r[ci_idx]        <= 1'b1;
        stk_next_r[depth_r] <= ci_r + VCNT_W'(1);
        stk_via_r[depth_r]  <= ci_idx;
        ci_r                <= ci_r + VCNT_W'(1);
      end
      OP_HIT_DESC: begin
        cv_r[ci_idx]                      <= 1'b1;
        stk_next_r[depth_r]               <= ci_r + VCNT_W'(1);
        stk_via_r[depth_r]                <= ci_idx;
        depth_r                           <= depth_r + VIDX_W'(1);
        stk_row_r[depth_r + VIDX_W'(1)]   <= partner_row;
        stk_next_r[depth_r + VIDX_W'(1)]  <= '0;
        stk_via_r[depth_r + VIDX_W'(1)]   <= '0;
        rv_r[partner_row]                 <= 1'b1;
        ci_r                              <= '0;
      end
      OP_POP: begin
        depth_r <= depth_m1;
        ci_r    <= stk_next_r[depth_m1];
      end
      OP_AUG: begin
        // flip the path, deepest frame first
        partner_r[stk_via_r[depth_r]] <= {1'b0, stk_row_r[depth_r]} + VCNT_W'(1);
        if (depth_r == '0) begin
          start_r <= start_r + VIDX_W'(1);
          ri_r    <= '0;
          ci_r    <= '0;
          total_r <= '0;
        end else begin
          depth_r <= depth_m1;
        end
      end
      OP_ADJ_INIT: begin
        found_r <= 1'b0;
        delta_r <= '0;
        ri_r    <= '0;
        ci_r    <= '0;
      end
      OP_ADJ_SKIP_ROW: begin
        ri_r <= ri_r + VIDX_W'(1);
        ci_r <= '0;
      end
      OP_ADJ_SKIP_COL, OP_ADJ_ACC: begin
        if ((cmd == OP_ADJ_ACC) && (!found_r || (slack < delta_r))) begin
          delta_r <= slack;
          found_r <= 1'b1;
        end
        if (st.ci_last) begin
          ci_r <= '0;
          ri_r <= ri_r + VIDX_W'(1);
        end else begin
          ci_r <= ci_r + VCNT_W'(1);
        end
      end
      OP_APPLY: begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
          if (found_r && rv_r[k]) begin
            rl_r[k] <= rl_r[k] - delta_r;
          end
          if (found_r && cv_r[k]) begin
            cl_r[k] <= cl_r[k] + delta_r;
          end
        end
      end
      OP_TOT: begin
        // row and column counters step together
        total_r <= total_r + pair_sum;
        ri_r    <= ri_r + VIDX_W'(1);
        ci_r    <= st.ri_last ? '0 : ci_r + VCNT_W'(1);
      end
      OP_EMIT: begin
        out_column_r       <= ci_idx;
        out_matched_row_r  <= (partner_v != '0) ? partner_row : '0;
        out_total_weight_r <= st.ci_last ? total_r[TOTAL_W-1:0] : '0;
        out_last_r         <= st.ci_last;
        ci_r               <= ci_r + VCNT_W'(1);
      end
      OP_NONE, OP_CLEAR, OP_WRITE, OP_MAX_RD, OP_ADJ_RD: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_column       = out_column_r;
  assign out_matched_row  = out_matched_row_r;
  assign out_total_weight = out_total_weight_r;
  assign out_last         = out_last_r;

  // a column on the augmenting path was visited in this search
  `MWBM_ASSERT_NOW(a_aug_col_visited, clk, rst_n, (cmd != OP_AUG) || cv_r[stk_via_r[depth_r]], "augmenting through an unvisited column")
  // an equality hit never lands on a column already visited
  `MWBM_ASSERT_NOW(a_hit_fresh_col, clk, rst_n, !((cmd == OP_HIT_FREE) || (cmd == OP_HIT_DESC) || (cmd == OP_HIT_STAY)) || !cv_r[ci_idx], "hit on visited column")
  // a label update always has a slack to apply
  `MWBM_ASSERT_NOW(a_apply_found, clk, rst_n, (cmd != OP_APPLY) || found_r, "label update without a slack")
  // the final column of a solve is flagged last
  `MWBM_ASSERT_NEXT(a_emit_last, clk, rst_n, (cmd == OP_EMIT) && st.ci_last, out_valid_r && out_last_r, "last flag missing")

endmodule
`default_nettype wire

// ===== design/max_weight_bipartite_matching_top.sv =====
// ---------------------------------------------------------------------------
// max_weight_bipartite_matching_top
// Hungarian maximum-weight assignment over a loaded weight matrix
// ---------------------------------------------------------------------------
// Input items arrive on in_valid/in_stall: op 0 clears every weight to absent,
// op 1 stores one edge weight, op 2 solves; op 3 is dropped. Clear and write
// items are taken while idle, so a loader can stream one weight per cycle
// when no solve runs. A solve holds in_stall high for its whole run: row
// maxima, then per row an equality search over tight edges with label
// adjustments, then the total and the n results. The single read port of
// the weight memory paces these steps; the worst case grows as n^4 memory
// reads. Results leave on out_valid/out_stall, one per column from 0 to n-1;
// the final one carries the total and last. A held result stays put while
// the receiver stalls, and the block takes the next item behind it.
// active_size (cfg_we/cfg_wdata) is to be written by the user only while
// idle; the block does not enforce it. Reset, synchronous and active low,
// marks every weight absent and sets the size to 16.
// ---------------------------------------------------------------------------
`default_nettype none
module max_weight_bipartite_matching_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [mwbm_pkg::SIZE_W-1:0]           cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_op,
  input  logic [mwbm_pkg::VIDX_W-1:0]           in_row_index,
  input  logic [mwbm_pkg::VIDX_W-1:0]           in_col_index,
  input  logic signed [mwbm_pkg::WEIGHT_W-1:0]  in_edge_weight,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mwbm_pkg::VIDX_W-1:0]           out_column,
  output logic [mwbm_pkg::VIDX_W-1:0]           out_matched_row,
  output logic signed [mwbm_pkg::TOTAL_W-1:0]   out_total_weight,
  output logic                                  out_last
);
  import mwbm_pkg::*;

  dp_op_t     cmd;
  dp_status_t st;
  in_op_t     op_code;

  assign op_code = in_op_t'(in_op);

  // sequencer
  mwbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (op_code),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // storage and arithmetic
  mwbm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_edge_weight   (in_edge_weight),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_column       (out_column),
    .out_matched_row  (out_matched_row),
    .out_total_weight (out_total_weight),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

// ===== test/max_weight_bipartite_matching_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// max_weight_bipartite_matching_top_test
// Self-checking bench for the Hungarian assignment block. Weight loads, clears
// and solves are driven through the item handshake. A behavioural model of
// the labelled augmenting-path search predicts every column result and the
// total. Both handshake sides idle and stall at random, with a long hold-off
// on the result side and a full drain pause on the input side.
// ---------------------------------------------------------------------------
`default_nettype none
module max_weight_bipartite_matching_top_test;
  import mwbm_pkg::*;

  localparam int  NV         = 16;
  localparam int  ABSENT     = -(1 << 28);
  localparam int  CYCLE_CAP  = 4000000;
  localparam int  SETTLE     = 40;

  typedef struct packed {
    logic [3:0]  column;
    logic [3:0]  matched_row;
    logic [32:0] total;
    logic        last;
  } col_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [SIZE_W-1:0]          cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_op = OPC_NONE;
  logic [VIDX_W-1:0]          in_row_index = '0;
  logic [VIDX_W-1:0]          in_col_index = '0;
  logic signed [WEIGHT_W-1:0] in_edge_weight = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [VIDX_W-1:0]          out_column;
  logic [VIDX_W-1:0]          out_matched_row;
  logic signed [TOTAL_W-1:0]  out_total_weight;
  logic                       out_last;

  // model state
  int     weights [NV*NV];
  longint row_lbl [NV];
  longint col_lbl [NV];
  bit     row_seen [NV];
  bit     col_seen [NV];
  int     partner [NV];
  int     stk_row [NV];
  int     stk_next [NV];
  int     stk_via [NV];
  int     size_reg = 16;

  col_result_t pending_cols [$];
  bit          failed = 1'b0;
  int          items_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          cycle_count = 0;

  max_weight_bipartite_matching_top i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_edge_weight(in_edge_weight), .out_valid(out_valid),
    .out_stall(out_stall), .out_column(out_column),
    .out_matched_row(out_matched_row), .out_total_weight(out_total_weight),
    .out_last(out_last)
  );

  always #2 clk = ~clk;

  // ---------------- assignment model ----------------
  function automatic int active_n();
    if (size_reg < 1) return 1;
    if (size_reg > NV) return NV;
    return size_reg;
  endfunction

  function automatic void clear_weights();
    for (int k = 0; k < NV*NV; k++) weights[k] = ABSENT;
  endfunction

  // depth-first augmenting search over tight edges from one row
  function automatic bit augment_from(int start, int n);
    int depth;
    int u;
    int v;
    int r;
    bit desc;
    depth = 0;
    stk_row[0] = start;
    stk_next[0] = 0;
    stk_via[0] = 0;
    row_seen[start] = 1'b1;
    forever begin
      u = stk_row[depth];
      desc = 1'b0;
      for (v = stk_next[depth]; v < n; v++) begin
        if (col_seen[v] || row_lbl[u] + col_lbl[v] != longint'(weights[u*NV+v]))
          continue;
        col_seen[v] = 1'b1;
        stk_next[depth] = v + 1;
        stk_via[depth] = v;
        if (partner[v] == 0) begin
          for (int k = depth; k >= 0; k--) partner[stk_via[k]] = stk_row[k] + 1;
          return 1'b1;
        end
        if (depth + 1 < NV) begin
          r = partner[v] - 1;
          depth++;
          stk_row[depth] = r;
          stk_next[depth] = 0;
          stk_via[depth] = 0;
          row_seen[r] = 1'b1;
          desc = 1'b1;
          break;
        end
      end
      if (!desc) begin
        stk_next[depth] = n;
        if (depth == 0) return 1'b0;
        depth--;
      end
    end
  endfunction

  // shift labels by the minimum slack between seen rows and unseen columns
  function automatic void shift_labels(int n);
    bit     found;
    longint delta;
    longint s;
    found = 1'b0;
    delta = 0;
    for (int i = 0; i < n; i++) begin
      if (!row_seen[i]) continue;
      for (int j = 0; j < n; j++) begin
        if (col_seen[j]) continue;
        s = row_lbl[i] + col_lbl[j] - longint'(weights[i*NV+j]);
        if (!found || s < delta) begin
          delta = s;
          found = 1'b1;
        end
      end
    end
    if (!found) return;
    for (int i = 0; i < n; i++) if (row_seen[i]) row_lbl[i] -= delta;
    for (int j = 0; j < n; j++) if (col_seen[j]) col_lbl[j] += delta;
  endfunction

  function automatic void solve_assignment();
    int          n;
    longint      m;
    longint      total;
    col_result_t res;
    n = active_n();
    total = 0;
    for (int i = 0; i < NV; i++) begin
      row_lbl[i] = 0;
      col_lbl[i] = 0;
      partner[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      m = ABSENT;
      for (int j = 0; j < n; j++) if (weights[i*NV+j] > m) m = weights[i*NV+j];
      row_lbl[i] = m;
    end
    for (int i = 0; i < n; i++) begin
      forever begin
        for (int k = 0; k < NV; k++) begin
          row_seen[k] = 1'b0;
          col_seen[k] = 1'b0;
        end
        if (augment_from(i, n)) break;
        shift_labels(n);
      end
    end
    for (int i = 0; i < n; i++) total += row_lbl[i] + col_lbl[i];
    for (int j = 0; j < n; j++) begin
      res.column = j[3:0];
      res.matched_row = partner[j] != 0 ? 4'(partner[j] - 1) : 4'd0;
      res.last = (j == n - 1);
      res.total = res.last ? total[32:0] : 33'd0;
      pending_cols.push_back(res);
    end
  endfunction

  function automatic void apply_item(in_op_t op, int r, int c, logic signed [20:0] w);
    case (op)
      OPC_CLEAR: clear_weights();
      OPC_WRITE: weights[r*NV+c] = int'(w);
      OPC_SOLVE: solve_assignment();
      default: ;
    endcase
  endfunction

  // ---------------- handshake helpers ----------------
  task automatic send_item(in_op_t op, int r, int c, logic signed [20:0] w);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_op = op;
    in_row_index = r[3:0];
    in_col_index = c[3:0];
    in_edge_weight = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    apply_item(op, r, c, w);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_cols.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_size(int v);
    wait_drained();
    cfg_wdata = v[4:0];
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    size_reg = v;
  endtask

  function automatic logic signed [20:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 21'sh100000;
      1: return 21'sh0FFFFF;
      2, 3: return 21'($urandom_range(0, 8)) - 21'sd4;
      default: return 21'($urandom_range(0, 2097151));
    endcase
  endfunction

  // one load-and-solve sequence at a given size
  task automatic run_problem(int sz);
    int n;
    set_size(sz);
    n = active_n();
    if ($urandom_range(0, 3) != 0) send_item(OPC_CLEAR, 0, 0, 0);
    if (n <= 6) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if ($urandom_range(0, 9) != 0) send_item(OPC_WRITE, i, j, pick_weight());
    end else begin
      repeat (n + 4)
        send_item(OPC_WRITE, $urandom_range(0, n-1), $urandom_range(0, n-1), pick_weight());
    end
    // noise: stale writes that may fall outside the corner and dropped op codes
    if ($urandom_range(0, 2) == 0)
      send_item(OPC_WRITE, $urandom_range(0, 15), $urandom_range(0, 15), pick_weight());
    if ($urandom_range(0, 4) == 0) send_item(OPC_NONE, $urandom_range(0, 15),
                                              $urandom_range(0, 15), pick_weight());
    send_item(OPC_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), pick_weight());
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    set_size(0);
    send_item(OPC_SOLVE, 0, 0, 0);
    send_item(OPC_WRITE, 0, 0, 21'sh100000);
    send_item(OPC_SOLVE, 0, 0, 0);
    set_size(2);
    send_item(OPC_WRITE, 0, 0, 21'sh0FFFFF);
    send_item(OPC_WRITE, 0, 1, 21'sh0FFFFF);
    send_item(OPC_WRITE, 1, 0, 21'sh0FFFFF);
    send_item(OPC_WRITE, 1, 1, 21'sh100000);
    send_item(OPC_WRITE, 15, 15, 21'sh0FFFFF);
    send_item(OPC_NONE, 0, 0, 21'sd0);
    send_item(OPC_SOLVE, 0, 0, 0);
    send_item(OPC_WRITE, 0, 0, 21'sd5);
    send_item(OPC_SOLVE, 0, 0, 0);
    set_size(31);
    send_item(OPC_SOLVE, 0, 0, 0);
    send_item(OPC_CLEAR, 0, 0, 0);
    set_size(16);
    send_item(OPC_WRITE, 15, 0, 21'sd7);
    send_item(OPC_WRITE, 0, 15, -21'sd3);
    send_item(OPC_SOLVE, 0, 0, 0);
    set_size(3);
    send_item(OPC_SOLVE, 0, 0, 0);
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    int stop_at;
    idle_pct = idle;
    stall_pct = stall;
    stop_at = items_sent + count;
    while (items_sent < stop_at)
      run_problem($urandom_range(0, 9) == 0 ? $urandom_range(7, 31) : $urandom_range(1, 6));
  endtask

  task automatic test_backpressure();
    set_size(3);
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 600;
    repeat (3) begin
      send_item(OPC_WRITE, $urandom_range(0, 2), $urandom_range(0, 2), pick_weight());
      send_item(OPC_SOLVE, 0, 0, 0);
    end
  endtask

  task automatic test_drain_pause();
    run_problem(4);
    wait_drained();
    run_problem(5);
  endtask

  // ---------------- result side ----------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    col_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cols.size() == 0) begin
        $display("%0t: unexpected result col %0d row %0d", $time, out_column,
                 out_matched_row);
        failed = 1'b1;
      end else begin
        exp_r = pending_cols.pop_front();
        if (out_column !== exp_r.column || out_matched_row !== exp_r.matched_row ||
            out_total_weight !== exp_r.total || out_last !== exp_r.last) begin
          $display("%0t: expected col %0d row %0d total %0d last %0b", $time,
                   exp_r.column, exp_r.matched_row, $signed(exp_r.total), exp_r.last);
          $display("%0t: actual   col %0d row %0d total %0d last %0b", $time,
                   out_column, out_matched_row, out_total_weight, out_last);
          failed = 1'b1;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("max_weight_bipartite_matching_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    clear_weights();
    for (int i = 0; i < NV; i++) partner[i] = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_phase(0, 0, 70);
    test_backpressure();
    test_random_phase(56, 0, 60);
    test_drain_pause();
    test_random_phase(0, 56, 60);
    test_random_phase(29, 29, 70);
    wait_drained();
    repeat (100) @(negedge clk);
    if (!failed) begin
      $display("max_weight_bipartite_matching_top_test OK");
    end else begin
      $display("max_weight_bipartite_matching_top_test NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/mwbm_pkg.sv
design/mwbm_ctrl.sv
design/mwbm_dp.sv
design/max_weight_bipartite_matching_top.sv
test/max_weight_bipartite_matching_top_test.sv
